// File: rtl/csk_pkg.sv
package csk_pkg;

  localparam int CW   = 32;          // coordinate and result word
  localparam int FB   = 16;          // fractional bits
  localparam int HW   = 31;          // register width
  localparam int QW   = FB + 1;      // q, p, ux, uy
  localparam int GW   = FB + 2;      // g
  localparam int WMW  = HW + QW;     // a * poly
  localparam int PXW  = CW + QW;     // t * u
  localparam int IDXW = 1;

  localparam logic [HW-1:0]   H_RST      = HW'(1 << FB);
  localparam logic [HW-1:0]   A_RST      = HW'(29800);
  localparam logic [2*HW-1:0] HH_RST     = (2*HW)'(64'd1 << (2*FB));
  localparam logic [QW-1:0]   TWO_THIRDS = QW'((2 * (1 << FB) + 1) / 3);
  localparam logic [QW:0]     TWO_FX     = (QW+1)'(1 << (FB + 1));
  localparam logic [CW-1:0]   DIV6_K     = 32'hAAAA_AAAB;
  localparam int              DIV6_SH    = 34;
  localparam logic [CW-1:0]   POS_MAX    = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]   NEG_MAX    = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [IDXW-1:0] {
    REG_SMOOTH = 1'b0,
    REG_NORM   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    logic          nx;
    logic          ny;
    logic          far;
    logic          last;
  } geo_t;

  typedef struct packed {
    geo_t          geo;
    logic [CW-1:0] r;
  } qside_t;

  typedef struct packed {
    geo_t          geo;
    logic          reg1;
    logic [QW-1:0] p;
    logic [GW-1:0] g;
  } uside_t;

  typedef struct packed {
    logic [CW-1:0] w;
    logic          ovx;
    logic          ovy;
    logic          negx;
    logic          negy;
    logic          far;
    logic          last;
  } gside_t;

  typedef struct packed {
    logic [CW-1:0] kv;
    logic [CW-1:0] gx;
    logic [CW-1:0] gy;
    logic          last;
  } res_t;

  function automatic logic [CW-1:0] sat_pos(input logic [CW-1:0] m);
    return m[CW-1] ? POS_MAX : m;
  endfunction

  function automatic logic [CW-1:0] sat_neg(input logic [CW-1:0] m);
    return (m > NEG_MAX) ? NEG_MAX : (CW'(0) - m);
  endfunction

endpackage

// File: rtl/cubic_spline_kernel_2d_top.sv
// 2D cubic spline smoothing kernel for one particle pair per word.
// Input stream: s_axis tdata carries both particle positions (signed Q16.16),
// tlast marks the last pair of a list and comes back on m_axis tlast.
// Output stream: kernel value and its x/y gradient, signed Q16.16, saturated.
// Config channel: index 0 writes the smoothing length h, index 1 the
// normalization a (both unsigned Q15.16, low 31 bits of the data). Writes
// are taken every cycle; change them only while no pair is in flight.
// Pipeline: 4 front stages, 32-stage square root, 17-stage q divide,
// region stage, 17-stage x/y unit divide, 5 multiply stages,
// 32-stage gradient divide, output buffer.
// Throughput: one pair per cycle while the output buffer is not full.
// A 2-word output buffer sits after the pipeline. The whole pipeline holds
// while the buffer is full; s_axis_tready then drops, nothing is lost.
// With m_axis_tready held high the pipeline never stalls.
// Reset clears all valid bits and the buffer, h = 1.0, a = 29800.
module cubic_spline_kernel_2d_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [4*csk_pkg::CW-1:0]  s_axis_tdata,   // first_x, first_y, second_x, second_y
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [3*csk_pkg::CW-1:0]  m_axis_tdata,   // kernel_value, gradient_x, gradient_y
  output logic                      m_axis_tlast,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  csk_pkg::cfg_reg_e         cfg_index_i,
  input  logic [csk_pkg::CW-1:0]    cfg_data_i
);
  import csk_pkg::*;

  logic [HW-1:0]   h_q, a_q;
  logic [2*HW-1:0] hh_q;
  logic            en;
  logic [1:0]      cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q  <= H_RST;
      a_q  <= A_RST;
      hh_q <= HH_RST;
    end else begin
      hh_q <= (2*HW)'(h_q) * (2*HW)'(h_q);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SMOOTH: h_q <= cfg_data_i[HW-1:0];
          REG_NORM:   a_q <= cfg_data_i[HW-1:0];
          default:    ;
        endcase
      end
    end
  end

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // S1: differences
  logic          s1_v_q, s1_last_q;
  logic [CW:0]   s1_dx_q, s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q   <= {s_axis_tdata[CW-1], s_axis_tdata[CW-1:0]}
                 - {s_axis_tdata[3*CW-1], s_axis_tdata[3*CW-1:2*CW]};
      s1_dy_q   <= {s_axis_tdata[2*CW-1], s_axis_tdata[2*CW-1:CW]}
                 - {s_axis_tdata[4*CW-1], s_axis_tdata[4*CW-1:3*CW]};
      s1_last_q <= s_axis_tlast;
    end
  end

  // S2: magnitudes, box test
  logic [CW:0] ax, ay;
  geo_t        s2_geo_d, s2_geo_q;
  logic        s2_v_q;

  always_comb begin
    ax = s1_dx_q[CW] ? ((CW+1)'(0) - s1_dx_q) : s1_dx_q;
    ay = s1_dy_q[CW] ? ((CW+1)'(0) - s1_dy_q) : s1_dy_q;
    s2_geo_d.mx   = ax[CW-1:0];
    s2_geo_d.my   = ay[CW-1:0];
    s2_geo_d.nx   = s1_dx_q[CW];
    s2_geo_d.ny   = s1_dy_q[CW];
    s2_geo_d.far  = (ax >= {1'b0, h_q, 1'b0}) | (ay >= {1'b0, h_q, 1'b0});
    s2_geo_d.last = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) s2_geo_q <= s2_geo_d;
  end

  // S3: squares
  logic [2*CW-1:0] s3_sx_q, s3_sy_q;
  geo_t            s3_geo_q;
  logic            s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sx_q  <= (2*CW)'(s2_geo_q.mx) * (2*CW)'(s2_geo_q.mx);
      s3_sy_q  <= (2*CW)'(s2_geo_q.my) * (2*CW)'(s2_geo_q.my);
      s3_geo_q <= s2_geo_q;
    end
  end

  // S4: r^2 and radius test
  logic [2*CW:0]   r2s;
  logic [2*CW-1:0] s4_r2_q;
  geo_t            s4_geo_d, s4_geo_q;
  logic            s4_v_q;

  always_comb begin
    r2s          = (2*CW+1)'(s3_sx_q) + (2*CW+1)'(s3_sy_q);
    s4_geo_d     = s3_geo_q;
    s4_geo_d.far = s3_geo_q.far | r2s[2*CW] | (r2s[2*CW-1:0] >= {hh_q, 2'b00});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_r2_q  <= r2s[2*CW-1:0];
      s4_geo_q <= s4_geo_d;
    end
  end

  // square root
  logic          sq_v;
  logic [CW-1:0] sq_root;
  geo_t          sq_geo;

  csk_sqrt #(.SW(CW), .side_t(geo_t)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(s4_v_q), .rad_i(s4_r2_q), .side_i(s4_geo_q),
    .valid_o(sq_v), .root_o(sq_root), .side_o(sq_geo)
  );

  // q = r / h
  qside_t        qd_side_in, qd_side;
  logic          qd_v;
  logic [QW-1:0] qd_q;

  assign qd_side_in.geo = sq_geo;
  assign qd_side_in.r   = sq_root;

  csk_div #(.QW(QW), .DW(CW), .LANES(1), .side_t(qside_t)) u_qdiv (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sq_v), .rem_i({1'b0, sq_root[CW-1:1]}),
    .num_i({sq_root[0], FB'(0)}), .den_i({1'b0, h_q}), .side_i(qd_side_in),
    .valid_o(qd_v), .quo_o(qd_q), .side_o(qd_side)
  );

  // P1: region, p, g, unit divisor
  logic [QW:0]   s_full;
  logic [QW+1:0] q3;
  uside_t        p1_d, p1_q;
  logic [CW-1:0] p1_den_d, p1_den_q;
  logic          p1_v_q;

  always_comb begin
    s_full    = TWO_FX - (QW+1)'(qd_q);
    q3        = (QW+2)'({qd_q, 1'b0}) + (QW+2)'(qd_q);
    p1_d.geo  = qd_side.geo;
    p1_d.reg1 = ~qd_q[QW-1];
    p1_d.p    = p1_d.reg1 ? qd_q : s_full[QW-1:0];
    p1_d.g    = GW'(TWO_FX) - q3[QW+1:1];
    p1_den_d  = p1_d.reg1 ? {1'b0, h_q} : qd_side.r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else if (en) p1_v_q <= qd_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q     <= p1_d;
      p1_den_q <= p1_den_d;
    end
  end

  // ux, uy
  logic [1:0][CW-1:0] ud_rem;
  logic [1:0][QW-1:0] ud_num, ud_quo;
  uside_t             ud_side;
  logic               ud_v;

  always_comb begin
    ud_rem[0] = {1'b0, p1_q.geo.mx[CW-1:1]};
    ud_rem[1] = {1'b0, p1_q.geo.my[CW-1:1]};
    ud_num[0] = {p1_q.geo.mx[0], FB'(0)};
    ud_num[1] = {p1_q.geo.my[0], FB'(0)};
  end

  csk_div #(.QW(QW), .DW(CW), .LANES(2), .side_t(uside_t)) u_udiv (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(p1_v_q), .rem_i(ud_rem), .num_i(ud_num), .den_i(p1_den_q),
    .side_i(p1_q), .valid_o(ud_v), .quo_o(ud_quo), .side_o(ud_side)
  );

  // M1: p^2
  logic [2*QW-1:0] pp;
  logic            m1_v_q;
  uside_t          m1_side_q;
  logic [QW-1:0]   m1_p2_q;
  logic [1:0][QW-1:0] m1_u_q;

  assign pp = (2*QW)'(ud_side.p) * (2*QW)'(ud_side.p);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m1_v_q <= 1'b0;
    else if (en) m1_v_q <= ud_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_side_q <= ud_side;
      m1_p2_q   <= pp[FB+QW-1:FB];
      m1_u_q    <= ud_quo;
    end
  end

  // M2: p^3, t
  logic [2*QW-1:0]  ppp;
  logic [HW+GW-1:0] tm;
  logic             m2_v_q;
  geo_t             m2_geo_q;
  logic             m2_reg1_q;
  logic [QW-1:0]    m2_p2_q, m2_p3_q;
  logic [CW-1:0]    m2_t_q;
  logic [1:0][QW-1:0] m2_u_q;

  assign ppp = (2*QW)'(m1_p2_q) * (2*QW)'(m1_side_q.p);
  assign tm  = (HW+GW)'(a_q)
             * (HW+GW)'(m1_side_q.reg1 ? m1_side_q.g : GW'(m1_p2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m2_v_q <= 1'b0;
    else if (en) m2_v_q <= m1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_geo_q  <= m1_side_q.geo;
      m2_reg1_q <= m1_side_q.reg1;
      m2_p2_q   <= m1_p2_q;
      m2_p3_q   <= ppp[FB+QW-1:FB];
      m2_t_q    <= m1_side_q.reg1 ? tm[FB+CW-1:FB] : tm[FB+CW:FB+1];
      m2_u_q    <= m1_u_q;
    end
  end

  // M3: polynomial
  logic [QW-1:0] hi, poly;
  logic          m3_v_q, m3_reg1_q;
  geo_t          m3_geo_q;
  logic [QW-1:0] m3_ws_q;
  logic [CW-1:0] m3_t_q;
  logic [1:0][QW-1:0] m3_u_q;

  assign hi   = TWO_THIRDS + (m2_p3_q >> 1);
  assign poly = (hi > m2_p2_q) ? (hi - m2_p2_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m3_v_q <= 1'b0;
    else if (en) m3_v_q <= m2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_geo_q  <= m2_geo_q;
      m3_reg1_q <= m2_reg1_q;
      m3_ws_q   <= m2_reg1_q ? poly : m2_p3_q;
      m3_t_q    <= m2_t_q;
      m3_u_q    <= m2_u_q;
    end
  end

  // M4: products
  logic           m4_v_q, m4_reg1_q;
  geo_t           m4_geo_q;
  logic [WMW-1:0] m4_wm_q;
  logic [PXW-1:0] m4_px_q, m4_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m4_v_q <= 1'b0;
    else if (en) m4_v_q <= m3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_geo_q  <= m3_geo_q;
      m4_reg1_q <= m3_reg1_q;
      m4_wm_q   <= WMW'(a_q) * WMW'(m3_ws_q);
      m4_px_q   <= PXW'(m3_t_q) * PXW'(m3_u_q[0]);
      m4_py_q   <= PXW'(m3_t_q) * PXW'(m3_u_q[1]);
    end
  end

  // M5: divide by 6 via reciprocal
  logic            m5_v_q, m5_reg1_q;
  geo_t            m5_geo_q;
  logic [CW-1:0]   m5_wh_q;
  logic [2*CW-1:0] m5_wk_q;
  logic [PXW-1:0]  m5_px_q, m5_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m5_v_q <= 1'b0;
    else if (en) m5_v_q <= m4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_geo_q  <= m4_geo_q;
      m5_reg1_q <= m4_reg1_q;
      m5_wh_q   <= m4_wm_q[FB+CW-1:FB];
      m5_wk_q   <= (2*CW)'(m4_wm_q[FB+CW-1:FB]) * (2*CW)'(DIV6_K);
      m5_px_q   <= m4_px_q;
      m5_py_q   <= m4_py_q;
    end
  end

  // gradient divide by h
  logic [HW-1:0]      hx, hy;
  logic [1:0][HW-1:0] gd_rem;
  logic [1:0][CW-1:0] gd_num, gd_quo;
  gside_t             gd_side_in, gd_side;
  logic               gd_v;

  always_comb begin
    hx              = HW'(m5_px_q[PXW-1:CW]);
    hy              = HW'(m5_py_q[PXW-1:CW]);
    gd_side_in.w    = m5_reg1_q ? m5_wh_q : CW'(m5_wk_q[2*CW-1:DIV6_SH]);
    gd_side_in.ovx  = hx >= h_q;
    gd_side_in.ovy  = hy >= h_q;
    gd_side_in.negx = ~m5_geo_q.nx & (m5_geo_q.mx != '0);
    gd_side_in.negy = ~m5_geo_q.ny & (m5_geo_q.my != '0);
    gd_side_in.far  = m5_geo_q.far;
    gd_side_in.last = m5_geo_q.last;
    gd_rem[0]       = gd_side_in.ovx ? '0 : hx;
    gd_rem[1]       = gd_side_in.ovy ? '0 : hy;
    gd_num[0]       = m5_px_q[CW-1:0];
    gd_num[1]       = m5_py_q[CW-1:0];
  end

  csk_div #(.QW(CW), .DW(HW), .LANES(2), .side_t(gside_t)) u_gdiv (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(m5_v_q), .rem_i(gd_rem), .num_i(gd_num), .den_i(h_q),
    .side_i(gd_side_in), .valid_o(gd_v), .quo_o(gd_quo), .side_o(gd_side)
  );

  // saturation
  logic [CW-1:0] magx, magy;
  res_t          res;

  always_comb begin
    magx     = gd_side.ovx ? '1 : gd_quo[0];
    magy     = gd_side.ovy ? '1 : gd_quo[1];
    res.kv   = gd_side.far ? '0 : sat_pos(gd_side.w);
    res.gx   = gd_side.far ? '0 : (gd_side.negx ? sat_neg(magx) : sat_pos(magx));
    res.gy   = gd_side.far ? '0 : (gd_side.negy ? sat_neg(magy) : sat_pos(magy));
    res.last = gd_side.last;
  end

  // output buffer
  res_t       buf_q [2];
  logic       wp_q, rp_q;
  logic       push, pop;
  logic [1:0] cnt_d;

  assign push  = en & gd_v;
  assign pop   = m_axis_tvalid & m_axis_tready;
  assign cnt_d = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= res;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {buf_q[rp_q].gy, buf_q[rp_q].gx, buf_q[rp_q].kv};
  assign m_axis_tlast  = buf_q[rp_q].last;

endmodule

// File: rtl/csk_div.sv
// pipelined restoring divider, one quotient bit per stage; rem_i < den_i
module csk_div #(
  parameter int  QW    = 17,
  parameter int  DW    = 32,
  parameter int  LANES = 1,
  parameter type side_t = logic
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [LANES-1:0][DW-1:0]      rem_i,
  input  logic [LANES-1:0][QW-1:0]      num_i,
  input  logic [DW-1:0]                 den_i,
  input  side_t                         side_i,
  output logic                          valid_o,
  output logic [LANES-1:0][QW-1:0]      quo_o,
  output side_t                         side_o
);

  logic                     vld [QW+1];
  logic [LANES-1:0][DW-1:0] rem [QW];
  logic [LANES-1:0][QW-1:0] nq  [QW+1];
  logic [DW-1:0]            den [QW];
  side_t                    sd  [QW+1];

  assign vld[0] = valid_i;
  assign rem[0] = rem_i;
  assign nq[0]  = num_i;
  assign den[0] = den_i;
  assign sd[0]  = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [LANES-1:0][DW:0]   tr;
    logic [LANES-1:0][DW:0]   df;
    logic [LANES-1:0]         ge;
    logic [LANES-1:0][DW-1:0] rem_n;
    logic [LANES-1:0][QW-1:0] nq_n;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        tr[l]    = {rem[k][l], nq[k][l][QW-1]};
        ge[l]    = tr[l] >= {1'b0, den[k]};
        df[l]    = tr[l] - {1'b0, den[k]};
        rem_n[l] = ge[l] ? df[l][DW-1:0] : tr[l][DW-1:0];
        nq_n[l]  = {nq[k][l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq[k+1] <= nq_n;
        sd[k+1] <= sd[k];
      end
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem[k+1] <= rem_n;
          den[k+1] <= den[k];
        end
      end
    end
  end

  assign valid_o = vld[QW];
  assign quo_o   = nq[QW];
  assign side_o  = sd[QW];

endmodule

// File: rtl/csk_sqrt.sv
// pipelined integer square root, one root bit per stage
module csk_sqrt #(
  parameter int  SW     = 32,
  parameter type side_t = logic
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*SW-1:0] rad_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [SW-1:0]   root_o,
  output side_t           side_o
);

  logic            vld [SW+1];
  logic [2*SW-1:0] rad [SW];
  logic [SW+1:0]   rm  [SW];
  logic [SW-1:0]   rt  [SW+1];
  side_t           sd  [SW+1];

  assign vld[0] = valid_i;
  assign rad[0] = rad_i;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign sd[0]  = side_i;

  for (genvar k = 0; k < SW; k++) begin : g_stg
    logic [SW+3:0] sh;
    logic [SW+3:0] tr;
    logic [SW+3:0] df;
    logic          ge;

    assign sh = {rm[k], rad[k][2*SW-1 -: 2]};
    assign tr = {2'b00, rt[k], 2'b01};
    assign ge = sh >= tr;
    assign df = sh - tr;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt[k+1] <= {rt[k][SW-2:0], ge};
        sd[k+1] <= sd[k];
      end
    end

    if (k < SW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rm[k+1]  <= ge ? df[SW+1:0] : sh[SW+1:0];
          rad[k+1] <= {rad[k][2*SW-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o = vld[SW];
  assign root_o  = rt[SW];
  assign side_o  = sd[SW];

endmodule

// File: rtl/csk_checker.sv
module csk_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [3*csk_pkg::CW-1:0] m_axis_tdata,
  input logic                     m_axis_tlast
);
  import csk_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_kernel_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[CW-1])
    else $error("negative kernel value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input held off without output backpressure");

endmodule

bind cubic_spline_kernel_2d_top csk_checker u_csk_checker (.*);
